// File: design/sst_pkg.sv
// Shared types, constants and letter mapping functions for the Serbian script transliterator.
package sst_pkg;

   localparam int CP_WIDTH     = 21;
   localparam int DATA_WIDTH   = 24;
   localparam int RESULT_DEPTH = 4;
   localparam int COUNT_WIDTH  = $clog2(RESULT_DEPTH + 1);

   localparam logic [1:0] MODE_CYR   = 2'd0;
   localparam logic [1:0] MODE_LAT   = 2'd1;
   localparam logic [1:0] MODE_ASCII = 2'd2;

   // register word index taken from the byte address
   localparam logic REG_MODE = 1'b0;

   typedef logic [CP_WIDTH-1:0] cp_type;

   typedef struct packed {
      cp_type first;
      cp_type second;
   } pair_type;

   typedef struct packed {
      cp_type first_cp;
      logic   has_second;
      cp_type second_cp;
      logic   digraph;
   } emit_type;

   function automatic logic cap_of(input cp_type c);
      return (c >= 21'd65 && c <= 21'd90) || (c >= 21'd1026 && c <= 21'd1064) ||
             c == 21'd262 || c == 21'd268 || c == 21'd272 || c == 21'd352 ||
             c == 21'd381;
   endfunction

   // Latin lower case a..z to Cyrillic lower case, zero where there is none
   function automatic cp_type lat_lower(input logic [4:0] i);
      case (i)
         5'd0:    return 21'd1072;
         5'd1:    return 21'd1073;
         5'd2:    return 21'd1094;
         5'd3:    return 21'd1076;
         5'd4:    return 21'd1077;
         5'd5:    return 21'd1092;
         5'd6:    return 21'd1075;
         5'd7:    return 21'd1093;
         5'd8:    return 21'd1080;
         5'd9:    return 21'd1112;
         5'd10:   return 21'd1082;
         5'd11:   return 21'd1083;
         5'd12:   return 21'd1084;
         5'd13:   return 21'd1085;
         5'd14:   return 21'd1086;
         5'd15:   return 21'd1087;
         5'd17:   return 21'd1088;
         5'd18:   return 21'd1089;
         5'd19:   return 21'd1090;
         5'd20:   return 21'd1091;
         5'd21:   return 21'd1074;
         5'd25:   return 21'd1079;
         default: return 21'd0;
      endcase
   endfunction

   // Cyrillic lower case from U+0430 up to ASCII lower case
   function automatic logic [6:0] cyr_lower(input logic [4:0] i);
      case (i)
         5'd0:    return 7'd97;
         5'd1:    return 7'd98;
         5'd2:    return 7'd118;
         5'd3:    return 7'd103;
         5'd4:    return 7'd100;
         5'd5:    return 7'd101;
         5'd7:    return 7'd122;
         5'd8:    return 7'd105;
         5'd10:   return 7'd107;
         5'd11:   return 7'd108;
         5'd12:   return 7'd109;
         5'd13:   return 7'd110;
         5'd14:   return 7'd111;
         5'd15:   return 7'd112;
         5'd16:   return 7'd114;
         5'd17:   return 7'd115;
         5'd18:   return 7'd116;
         5'd19:   return 7'd117;
         5'd20:   return 7'd102;
         5'd21:   return 7'd104;
         5'd22:   return 7'd99;
         default: return 7'd0;
      endcase
   endfunction

   function automatic cp_type to_cyr(input cp_type c, input cp_type nx);
      cp_type v;
      cp_type dl;
      cp_type du;
      logic   nx_zh;
      logic   nx_j;
      nx_zh = nx == 21'd381 || nx == 21'd382;
      nx_j  = nx == 21'd106 || nx == 21'd74;
      dl    = c - 21'd97;
      du    = c - 21'd65;
      if (nx_zh && c == 21'd100) return 21'd1119;
      if (nx_zh && c == 21'd68) return 21'd1039;
      if (nx_j) begin
         if (c == 21'd108) return 21'd1113;
         if (c == 21'd110) return 21'd1114;
         if (c == 21'd76) return 21'd1033;
         if (c == 21'd78) return 21'd1034;
      end
      if (c >= 21'd97 && c <= 21'd122) return lat_lower(dl[4:0]);
      if (c >= 21'd65 && c <= 21'd90) begin
         v = lat_lower(du[4:0]);
         if (v == 21'd0) return 21'd0;
         if (v == 21'd1112) return 21'd1032;
         return v - 21'd32;
      end
      case (c)
         21'd269: return 21'd1095;
         21'd273: return 21'd1106;
         21'd353: return 21'd1096;
         21'd263: return 21'd1115;
         21'd382: return 21'd1078;
         21'd268: return 21'd1063;
         21'd272: return 21'd1026;
         21'd352: return 21'd1064;
         21'd262: return 21'd1035;
         21'd381: return 21'd1046;
         default: return 21'd0;
      endcase
   endfunction

   function automatic pair_type to_lat(input cp_type c, input logic up2);
      pair_type r;
      cp_type   dl;
      cp_type   du;
      cp_type   v;
      r  = '0;
      dl = c - 21'd1072;
      du = c - 21'd1040;
      if (c < 21'd1026 || c > 21'd1119) return r;
      if (c == 21'd1078) begin
         r.first = 21'd382;
         return r;
      end
      if (c == 21'd1046) begin
         r.first = 21'd381;
         return r;
      end
      if (c >= 21'd1072 && c <= 21'd1094) begin
         r.first = {14'd0, cyr_lower(dl[4:0])};
         return r;
      end
      if (c >= 21'd1040 && c <= 21'd1062) begin
         v = {14'd0, cyr_lower(du[4:0])};
         r.first = (v != 21'd0) ? v - 21'd32 : 21'd0;
         return r;
      end
      case (c)
         21'd1112: r.first = 21'd106;
         21'd1115: r.first = 21'd263;
         21'd1095: r.first = 21'd269;
         21'd1096: r.first = 21'd353;
         21'd1106: r.first = 21'd273;
         21'd1113: begin
            r.first  = 21'd108;
            r.second = 21'd106;
         end
         21'd1114: begin
            r.first  = 21'd110;
            r.second = 21'd106;
         end
         21'd1119: begin
            r.first  = 21'd100;
            r.second = 21'd382;
         end
         21'd1032: r.first = 21'd74;
         21'd1035: r.first = 21'd262;
         21'd1063: r.first = 21'd268;
         21'd1064: r.first = 21'd352;
         21'd1026: r.first = 21'd272;
         21'd1033: begin
            r.first  = 21'd76;
            r.second = up2 ? 21'd74 : 21'd106;
         end
         21'd1034: begin
            r.first  = 21'd78;
            r.second = up2 ? 21'd74 : 21'd106;
         end
         21'd1039: begin
            r.first  = 21'd68;
            r.second = up2 ? 21'd381 : 21'd382;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic pair_type to_ascii(input cp_type c, input logic up2);
      pair_type r;
      r = '0;
      case (c)
         21'd263, 21'd269, 21'd1115, 21'd1095: r.first = 21'd99;
         21'd353, 21'd1096:                    r.first = 21'd115;
         21'd382, 21'd1078:                    r.first = 21'd122;
         21'd273, 21'd1106: begin
            r.first  = 21'd100;
            r.second = 21'd106;
         end
         21'd262, 21'd268, 21'd1035, 21'd1063: r.first = 21'd67;
         21'd352, 21'd1064:                    r.first = 21'd83;
         21'd381, 21'd1046:                    r.first = 21'd90;
         21'd272, 21'd1026: begin
            r.first  = 21'd68;
            r.second = up2 ? 21'd74 : 21'd106;
         end
         21'd1119: begin
            r.first  = 21'd100;
            r.second = up2 ? 21'd90 : 21'd122;
         end
         21'd1039: begin
            r.first  = 21'd68;
            r.second = up2 ? 21'd90 : 21'd122;
         end
         default: r = to_lat(c, up2);
      endcase
      return r;
   endfunction

   // Results for code point c with lookahead nx; unmapped code points pass through
   function automatic emit_type emit(input logic [1:0] mode, input cp_type c,
                                     input cp_type nx, input logic prev_cap);
      emit_type e;
      pair_type p;
      logic     up2;
      up2 = prev_cap || cap_of(nx);
      case (mode)
         MODE_CYR: begin
            p.first  = to_cyr(c, nx);
            p.second = '0;
         end
         MODE_LAT: p = to_lat(c, up2);
         default:  p = to_ascii(c, up2);
      endcase
      e.first_cp   = (p.first != '0) ? p.first : c;
      e.has_second = p.first != '0 && p.second != '0;
      e.second_cp  = p.second;
      e.digraph    = mode == MODE_CYR &&
                     (p.first == 21'd1113 || p.first == 21'd1114 || p.first == 21'd1119 ||
                      p.first == 21'd1033 || p.first == 21'd1034 || p.first == 21'd1039);
      return e;
   endfunction

endpackage

// File: design/serbian_script_transliterator.sv
// Serbian script transliterator: stream in, one code point per beat, with a one-deep lookahead.
//
// Input stream req_*: tdata[20:0] is the code point, tlast marks the end of the text.
// Result stream rsp_*: tdata[20:0] is the output code point, tuser marks the last result
// of one input beat, tlast marks the final result of the text.
// Register mode at byte address 0 (0 Latin to Cyrillic, 1 Cyrillic to Latin, 2 and 3
// Serbian to ASCII Latin); write it only while the block is idle.
// Each code point is held back until the next one arrives so that it can be mapped with
// that lookahead; a beat with nothing held gives no result unless it ends the text.
// A beat goes into the input register and, once the buffer is free, is mapped from there
// into a four-entry result buffer, from which its results are sent.
// A beat gives zero to four results; the buffer sends one per cycle while rsp_tready is high.
// The buffer takes the next beat's results in the cycle its last one leaves.
// When rsp_tready is low the buffer and then the input register hold and req_tready
// falls. Reset empties both, drops the held code point and sets mode to 0.
module serbian_script_transliterator
   import sst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic                  req_tlast,   // text_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,   // [20:0] out_code_point, [23:21] zero
   output logic                  rsp_tlast,   // text_end
   output logic                  rsp_tuser,   // run_last
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [1:0]             mode_ff, mode_in;
   logic                   in_valid_ff, in_valid_in;
   cp_type                 in_cp_ff;
   logic                   in_last_ff;
   cp_type                 held_cp_ff, held_cp_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   prev_cap_ff, prev_cap_in;
   cp_type                 buf_ff [RESULT_DEPTH];
   cp_type                 buf_in [RESULT_DEPTH];
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic                   end_ff, end_in;

   logic                   accept, buf_free, load, pop, csr_write;
   emit_type               e1, e2;
   logic                   prev_cap2, consumed, tail;
   logic [COUNT_WIDTH-1:0] n1, n2;
   cp_type                 slot [RESULT_DEPTH];

   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, mode_ff};
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       csr_paddr[2] == REG_MODE;
   assign mode_in    = csr_write ? csr_pwdata[1:0] : mode_ff;

   assign buf_free   = rem_ff == '0 || (rem_ff == COUNT_WIDTH'(1) && rsp_tready);
   assign load       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || load;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign rsp_tvalid = rem_ff != '0;
   assign rsp_tdata  = {3'd0, buf_ff[0]};
   assign rsp_tuser  = rem_ff == COUNT_WIDTH'(1);
   assign rsp_tlast  = rem_ff == COUNT_WIDTH'(1) && end_ff;

   // held code point against the new one, then the new one alone if it ends the text
   always_comb begin
      e1        = emit(mode_ff, held_cp_ff, in_cp_ff, prev_cap_ff);
      prev_cap2 = held_valid_ff ? cap_of(held_cp_ff) : prev_cap_ff;
      e2        = emit(mode_ff, in_cp_ff, '0, prev_cap2);
      consumed  = held_valid_ff && e1.digraph;
      tail      = in_last_ff && !consumed;
      n1        = held_valid_ff ? (e1.has_second ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1)) : '0;
      n2        = tail ? (e2.has_second ? COUNT_WIDTH'(2) : COUNT_WIDTH'(1)) : '0;
   end

   always_comb begin
      for (int i = 0; i < RESULT_DEPTH; i++) slot[i] = '0;
      slot[0] = e1.first_cp;
      slot[1] = e1.second_cp;
      case (n1)
         COUNT_WIDTH'(0): begin
            slot[0] = e2.first_cp;
            slot[1] = e2.second_cp;
         end
         COUNT_WIDTH'(1): begin
            slot[1] = e2.first_cp;
            slot[2] = e2.second_cp;
         end
         default: begin
            slot[2] = e2.first_cp;
            slot[3] = e2.second_cp;
         end
      endcase
   end

   always_comb begin
      in_valid_in   = accept || (in_valid_ff && !load);
      held_cp_in    = held_cp_ff;
      held_valid_in = held_valid_ff;
      prev_cap_in   = prev_cap_ff;
      rem_in        = rem_ff;
      end_in        = end_ff;
      buf_in        = buf_ff;
      // advance the buffer only when a beat leaves
      if (pop) begin
         rem_in = rem_ff - COUNT_WIDTH'(1);
         for (int i = 0; i < RESULT_DEPTH - 1; i++) buf_in[i] = buf_ff[i + 1];
      end
      if (load) begin
         buf_in = slot;
         rem_in = n1 + n2;
         end_in = in_last_ff;
         if (in_last_ff) begin
            held_valid_in = 1'b0;
            prev_cap_in   = 1'b0;
         end else if (consumed) begin
            held_valid_in = 1'b0;
            prev_cap_in   = cap_of(held_cp_ff);
         end else begin
            held_cp_in    = in_cp_ff;
            held_valid_in = 1'b1;
            prev_cap_in   = prev_cap2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CYR;
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         prev_cap_ff   <= 1'b0;
         rem_ff        <= '0;
      end else begin
         mode_ff       <= mode_in;
         in_valid_ff   <= in_valid_in;
         held_valid_ff <= held_valid_in;
         prev_cap_ff   <= prev_cap_in;
         rem_ff        <= rem_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cp_ff   <= req_tdata[CP_WIDTH-1:0];
         in_last_ff <= req_tlast;
      end
      held_cp_ff <= held_cp_in;
      end_ff     <= end_in;
      buf_ff     <= buf_in;
   end

endmodule

// File: design/sst_checker.sv
// Port-level checks for the Serbian script transliterator, bound to the top level.
module sst_checker
   import sst_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_WIDTH-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // the end of the text is always the end of a run
   a_end_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("text end without run end");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DATA_WIDTH-1:CP_WIDTH] == '0)
      else $error("result padding not zero");

   // reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind serbian_script_transliterator sst_checker u_sst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: sim/tb_top.sv
// Testbench for the Serbian script transliterator: letter scoreboard, stream drivers, mode writes.
`timescale 1ns / 100ps

class transliteration_board;
   typedef logic [sst_pkg::CP_WIDTH-1:0] letter_cp_type;

   typedef struct {
      letter_cp_type cp;
      logic          run_last;
      logic          text_end;
   } letter_type;

   letter_type expected_letters[$];
   letter_type run_letters[$];
   logic [1:0] mode         = sst_pkg::MODE_CYR;
   int         held_cp      = 0;
   bit         held_valid   = 0;
   bit         prev_capital = 0;
   int         items_in     = 0;
   int         failures     = 0;

   function void set_mode(logic [1:0] m);
      mode = m;
   endfunction

   function int pending();
      return expected_letters.size();
   endfunction

   function bit capital(int c);
      return (c >= 65 && c <= 90) || (c >= 1026 && c <= 1064) || c == 262 || c == 268 ||
             c == 272 || c == 352 || c == 381;
   endfunction

   // lower case Latin a..z by index to lower case Cyrillic, zero where none
   function int cyr_for_latin(int i);
      case (i)
         0: return 1072;   1: return 1073;   2: return 1094;   3: return 1076;
         4: return 1077;   5: return 1092;   6: return 1075;   7: return 1093;
         8: return 1080;   9: return 1112;  10: return 1082;  11: return 1083;
        12: return 1084;  13: return 1085;  14: return 1086;  15: return 1087;
        17: return 1088;  18: return 1089;  19: return 1090;  20: return 1091;
        21: return 1074;  25: return 1079;
         default: return 0;
      endcase
   endfunction

   // lower case Cyrillic from U+0430 by index to ASCII lower case, zero where none
   function int latin_for_cyr(int i);
      case (i)
         0: return 97;    1: return 98;    2: return 118;   3: return 103;
         4: return 100;   5: return 101;   7: return 122;   8: return 105;
        10: return 107;  11: return 108;  12: return 109;  13: return 110;
        14: return 111;  15: return 112;  16: return 114;  17: return 115;
        18: return 116;  19: return 117;  20: return 102;  21: return 104;
        22: return 99;
         default: return 0;
      endcase
   endfunction

   function int latin_to_cyr_letter(int c, int nx);
      int v;
      if ((nx == 381 || nx == 382) && c == 100) return 1119;
      if ((nx == 381 || nx == 382) && c == 68) return 1039;
      if (nx == 106 || nx == 74) begin
         if (c == 108) return 1113;
         if (c == 110) return 1114;
         if (c == 76) return 1033;
         if (c == 78) return 1034;
      end
      if (c >= 97 && c <= 122) return cyr_for_latin(c - 97);
      if (c >= 65 && c <= 90) begin
         v = cyr_for_latin(c - 65);
         if (v == 0) return 0;
         return (v == 1112) ? 1032 : v - 32;
      end
      case (c)
         269: return 1095;
         273: return 1106;
         353: return 1096;
         263: return 1115;
         382: return 1078;
         268: return 1063;
         272: return 1026;
         352: return 1064;
         262: return 1035;
         381: return 1046;
         default: return 0;
      endcase
   endfunction

   function int cyr_to_latin_letter(int c, bit up2, output int second);
      int v;
      second = 0;
      if (c < 1026 || c > 1119) return 0;
      if (c == 1078) return 382;
      if (c == 1046) return 381;
      if (c >= 1072 && c <= 1094) return latin_for_cyr(c - 1072);
      if (c >= 1040 && c <= 1062) begin
         v = latin_for_cyr(c - 1040);
         return (v != 0) ? v - 32 : 0;
      end
      case (c)
         1112: return 106;
         1115: return 263;
         1095: return 269;
         1096: return 353;
         1106: return 273;
         1113: begin
            second = 106;
            return 108;
         end
         1114: begin
            second = 106;
            return 110;
         end
         1119: begin
            second = 382;
            return 100;
         end
         1032: return 74;
         1035: return 262;
         1063: return 268;
         1064: return 352;
         1026: return 272;
         1033: begin
            second = up2 ? 74 : 106;
            return 76;
         end
         1034: begin
            second = up2 ? 74 : 106;
            return 78;
         end
         1039: begin
            second = up2 ? 381 : 382;
            return 68;
         end
         default: return 0;
      endcase
   endfunction

   function int to_plain_ascii(int c, bit up2, output int second);
      second = 0;
      case (c)
         263, 269, 1115, 1095: return 99;
         353, 1096:            return 115;
         382, 1078:            return 122;
         273, 1106: begin
            second = 106;
            return 100;
         end
         262, 268, 1035, 1063: return 67;
         352, 1064:            return 83;
         381, 1046:            return 90;
         272, 1026: begin
            second = up2 ? 74 : 106;
            return 68;
         end
         1119: begin
            second = up2 ? 90 : 122;
            return 100;
         end
         1039: begin
            second = up2 ? 90 : 122;
            return 68;
         end
         default: return cyr_to_latin_letter(c, up2, second);
      endcase
   endfunction

   // Map one held code point into run_letters; true when it swallows its lookahead
   function bit map_held(int c, int nx);
      int         first;
      int         second;
      bit         up2;
      letter_type l;
      up2    = prev_capital || capital(nx);
      second = 0;
      case (mode)
         sst_pkg::MODE_CYR: first = latin_to_cyr_letter(c, nx);
         sst_pkg::MODE_LAT: first = cyr_to_latin_letter(c, up2, second);
         default:           first = to_plain_ascii(c, up2, second);
      endcase
      l.cp       = letter_cp_type'((first != 0) ? first : c);
      l.run_last = 1'b0;
      l.text_end = 1'b0;
      run_letters.push_back(l);
      if (first != 0 && second != 0) begin
         l.cp = letter_cp_type'(second);
         run_letters.push_back(l);
      end
      prev_capital = capital(c);
      return mode == sst_pkg::MODE_CYR &&
             (first == 1113 || first == 1114 || first == 1119 ||
              first == 1033 || first == 1034 || first == 1039);
   endfunction

   function void note_code_point(letter_cp_type cp, logic last);
      int         c;
      letter_type l;
      c = int'(cp);
      items_in++;
      run_letters.delete();
      if (held_valid) begin
         if (map_held(held_cp, c)) begin
            held_valid = 0;
            held_cp    = 0;
         end else begin
            held_cp = c;
         end
      end else begin
         held_cp    = c;
         held_valid = 1;
      end
      if (last) begin
         // flush with no lookahead
         if (held_valid) void'(map_held(held_cp, 0));
         held_valid   = 0;
         held_cp      = 0;
         prev_capital = 0;
      end
      if (run_letters.size() > 0) begin
         l          = run_letters.pop_back();
         l.run_last = 1'b1;
         l.text_end = last;
         run_letters.push_back(l);
      end
      foreach (run_letters[i]) expected_letters.push_back(run_letters[i]);
   endfunction

   function void compare_field(string name, letter_cp_type want, letter_cp_type got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function void check_letter(letter_cp_type cp, logic run_last, logic text_end);
      letter_type want;
      if (expected_letters.size() == 0) begin
         $error("result beat with nothing expected: out_code_point %0d", cp);
         failures++;
         return;
      end
      want = expected_letters.pop_front();
      compare_field("out_code_point", want.cp, cp);
      compare_field("run_last", letter_cp_type'(want.run_last), letter_cp_type'(run_last));
      compare_field("text_end", letter_cp_type'(want.text_end), letter_cp_type'(text_end));
   endfunction
endclass

module tb_top;
   import sst_pkg::*;

   localparam logic [2:0] MODE_ADDR      = {REG_MODE, 2'b00};
   localparam logic [1:0] MODE_ASCII_ALT = 2'd3;
   localparam int         STALL_LIMIT    = 2000;
   localparam int         HOLD_AFTER     = 200;
   localparam int         HOLD_CYCLES    = 300;

   localparam int LATIN_MARKED [10] = '{262, 263, 268, 269, 272, 273, 352, 353, 381, 382};
   localparam int CYR_SPLITS [8]    = '{1113, 1114, 1119, 1033, 1034, 1039, 1106, 1026};
   localparam int LJ_LEADS [4]      = '{108, 110, 76, 78};
   localparam int DIRECTED [3][8]   = '{
      '{76, 106, 110, 74, 68, 382, 100, 381},
      '{0, 1033, 65, 1034, 97, 1113, 1119, 1039},
      '{1114111, 272, 1026, 97, 273, 1106, 1039, 2097151}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata;    // [20:0] code_point, [23:21] zero
   logic                  req_tlast;    // text_last
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_WIDTH-1:0] rsp_tdata;    // [20:0] out_code_point, [23:21] zero
   logic                  rsp_tlast;    // text_end
   logic                  rsp_tuser;    // run_last
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [2:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   transliteration_board board = new();
   int text_buf[$];
   bit calm;
   bit sender_gaps;

   serbian_script_transliterator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR)
            board.set_mode(csr_pwdata[1:0]);
         if (req_tvalid && req_tready)
            board.note_code_point(req_tdata[CP_WIDTH-1:0], req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_letter(rsp_tdata[CP_WIDTH-1:0], rsp_tuser, rsp_tlast);
      end
   end

   task automatic send_code_point(input int cp, input bit last);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_WIDTH'(cp);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      // let the last beat clear the input register
      repeat (4) @(posedge clock);
   endtask

   task automatic change_mode(input logic [1:0] m);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {30'd0, m};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Append a letter, a digraph pair or noise to the text being built
   task automatic add_piece();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         text_buf.push_back(int'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25)));
      end else if (r < 40) begin
         text_buf.push_back(LATIN_MARKED[$urandom_range(0, 9)]);
      end else if (r < 55) begin
         text_buf.push_back(int'($urandom_range(1026, 1119)));
      end else if (r < 65) begin
         text_buf.push_back(CYR_SPLITS[$urandom_range(0, 7)]);
      end else if (r < 85) begin
         if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back($urandom_range(0, 1) ? 100 : 68);
            text_buf.push_back($urandom_range(0, 1) ? 382 : 381);
         end else begin
            text_buf.push_back(LJ_LEADS[$urandom_range(0, 3)]);
            text_buf.push_back($urandom_range(0, 1) ? 106 : 74);
         end
      end else if (r < 93) begin
         text_buf.push_back(int'($urandom_range(0, 127)));
      end else begin
         text_buf.push_back(int'($urandom() & 32'h001F_FFFF));
      end
   endtask

   initial begin : receiver
      bit held_long;
      held_long = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_long && board.items_in >= HOLD_AFTER) begin
            // hold off long enough for the block to back up its input
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_long = 1;
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("** serbian_script_transliterator: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int         p;
      int         i;
      int         len;
      int         count;
      logic [1:0] phase_mode;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      calm        = 0;
      sender_gaps = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // digraphs, splits, capital lookahead and the code point extremes
      for (p = 0; p < 3; p++) begin
         change_mode(p == 0 ? MODE_CYR : (p == 1 ? MODE_LAT : MODE_ASCII));
         sender_gaps = 1'($urandom_range(0, 1));
         for (i = 0; i < 8; i++) send_code_point(DIRECTED[p][i], i == 7);
      end

      for (p = 0; p < 7; p++) begin
         calm = (p == 6);
         case (p)
            0:       phase_mode = MODE_LAT;
            1:       phase_mode = MODE_CYR;
            2:       phase_mode = MODE_ASCII_ALT;
            3:       phase_mode = MODE_ASCII;
            default: phase_mode = 2'($urandom_range(0, 3));
         endcase
         change_mode(phase_mode);
         count = 0;
         while (count < 65) begin
            len = $urandom_range(1, 10);
            text_buf.delete();
            while (text_buf.size() < len) add_piece();
            sender_gaps = !calm && $urandom_range(0, 2) != 0;
            foreach (text_buf[k]) send_code_point(text_buf[k], k == text_buf.size() - 1);
            count += text_buf.size();
         end
      end

      wait_drained();
      if (board.failures == 0) $display("** serbian_script_transliterator: PASSED **");
      else $display("** serbian_script_transliterator: FAILED **");
      $finish;
   end
endmodule

// File: files.f
design/sst_pkg.sv
design/serbian_script_transliterator.sv
design/sst_checker.sv
sim/tb_top.sv
